### sv/olst_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// olst_pkg : shared types for the ordered list engine
// Operation and status codes, and the command and status groups that join
// the controller to the datapath.
// ----------------------------------------------------------------------------
package olst_pkg;

    localparam int KIND_W = 3;
    localparam int VAL_W  = 32;
    localparam int POS_W  = 16;
    localparam int STAT_W = 3;

    // Operation code that is accepted but does nothing.
    localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;

    typedef enum logic [KIND_W-1:0] {
        K_INS_FIRST = 3'd0,
        K_INS_LAST  = 3'd1,
        K_INS_AT    = 3'd2,
        K_DEL_FIRST = 3'd3,
        K_DEL_LAST  = 3'd4,
        K_DEL_AT    = 3'd5,
        K_SEARCH    = 3'd6
    } op_kind_t;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE     = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_BADPOS   = 3'd2,
        ST_FULL     = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_TOP,
        PTR_IDX,
        PTR_ZERO,
        PTR_INC,
        PTR_DEC
    } ptr_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } cnt_op_t;

    // Read modes: a plain read, a read whose data moves one place up or
    // down, or a read whose data is compared against the search value.
    typedef enum logic [2:0] {
        RD_NONE,
        RD_PLAIN,
        RD_UP,
        RD_DN,
        RD_SCAN
    } rd_mode_t;

    typedef enum logic [1:0] {
        DSEL_ZERO,
        DSEL_VALUE,
        DSEL_REMOVED
    } dsel_t;

    typedef enum logic [1:0] {
        WSEL_ZERO,
        WSEL_IDX,
        WSEL_PEND
    } wsel_t;

    typedef struct packed {
        logic     load;
        ptr_op_t  ptr_op;
        rd_mode_t rd_mode;
        logic     cap_data;
        logic     wr_new;
        cnt_op_t  cnt_op;
        logic     emit;
        status_t  emit_status;
        dsel_t    data_sel;
        wsel_t    where_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic cnt_zero;
        logic cnt_full;
        logic ins_bad;
        logic del_bad;
        logic ptr_at_top;
        logic ptr_at_idx;
        logic idx_at_top;
        logic idx_eq_cnt;
        logic pend_vld;
    } dp_stat_t;

endpackage
`default_nettype wire

### sv/olst_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// olst_dp : ordered list datapath
// Entry memory with a registered read port, entry count, scan pointer, the
// move and compare pipelines, and the result register.
// ----------------------------------------------------------------------------
module olst_dp #(
    parameter int DEPTH = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [olst_pkg::KIND_W-1:0]       kind,
    input  wire logic [olst_pkg::VAL_W-1:0]        value,
    input  wire logic [olst_pkg::POS_W-1:0]        position,
    input  wire olst_pkg::dp_cmd_t                 cmd,
    output olst_pkg::dp_stat_t                     stat,
    output logic                                   strobe,
    output logic [olst_pkg::STAT_W-1:0]            status,
    output logic [olst_pkg::VAL_W-1:0]             data_out,
    output logic [olst_pkg::POS_W-1:0]             where,
    output logic [$clog2(DEPTH+1)-1:0]             length,
    output logic                                   last
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = olst_pkg::POS_W;

    logic [olst_pkg::VAL_W-1:0] mem [DEPTH];

    logic [CW-1:0]  count_reg, count_next;
    logic [AW-1:0]  ptr_reg, ptr_next;
    logic [AW-1:0]  idx_reg, idx_load;
    logic [olst_pkg::VAL_W-1:0] value_reg, rd_data_reg, removed_reg;
    logic [PW-1:0]  pos_reg;
    logic           mv_vld_reg;
    logic [AW-1:0]  mv_dst_reg;
    logic           sc_vld_reg;
    logic [CW-1:0]  sc_pos_reg;
    logic           pend_vld_reg;
    logic [CW-1:0]  pend_pos_reg;
    logic           hit;

    logic [CW-1:0]  ptr_p1, idx_p1;
    logic [PW:0]    cnt_w, pos_w;
    logic [PW-1:0]  pos_m1;

    logic                        strobe_reg, strobe_next;
    logic [olst_pkg::STAT_W-1:0] status_reg, status_next;
    logic [olst_pkg::VAL_W-1:0]  data_reg, data_next;
    logic [PW-1:0]               where_reg, where_next;
    logic [CW-1:0]               length_reg;
    logic                        last_reg, last_next;

    assign ptr_p1 = CW'(ptr_reg) + CW'(1);
    assign idx_p1 = CW'(idx_reg) + CW'(1);
    assign cnt_w  = (PW + 1)'(count_reg);
    assign pos_w  = {1'b0, pos_reg};
    assign pos_m1 = position - PW'(1);

    // Target index of the operation, worked out at acceptance from the count or the position.
    always_comb
    begin
        unique case (olst_pkg::op_kind_t'(kind))
            olst_pkg::K_INS_LAST: idx_load = AW'(count_reg);
            olst_pkg::K_DEL_LAST: idx_load = AW'(count_reg - CW'(1));
            olst_pkg::K_INS_AT,
            olst_pkg::K_DEL_AT:   idx_load = AW'(pos_m1);
            default:              idx_load = '0;
        endcase
    end

    assign stat.cnt_zero   = (count_reg == '0);
    assign stat.cnt_full   = (count_reg == CW'(DEPTH));
    assign stat.ins_bad    = (pos_reg == '0) || (pos_w > cnt_w + (PW + 1)'(1));
    assign stat.del_bad    = (pos_reg == '0) || (pos_w > cnt_w);
    assign stat.ptr_at_top = (ptr_p1 == count_reg);
    assign stat.ptr_at_idx = (ptr_reg == idx_reg);
    assign stat.idx_at_top = (idx_p1 == count_reg);
    assign stat.idx_eq_cnt = (CW'(idx_reg) == count_reg);
    assign stat.pend_vld   = pend_vld_reg;

    assign hit = sc_vld_reg && (rd_data_reg == value_reg);

    always_comb
    begin
        unique case (cmd.cnt_op)
            olst_pkg::CNT_INC: count_next = count_reg + CW'(1);
            olst_pkg::CNT_DEC: count_next = count_reg - CW'(1);
            default:           count_next = count_reg;
        endcase
    end

    always_comb
    begin
        unique case (cmd.ptr_op)
            olst_pkg::PTR_TOP:  ptr_next = AW'(count_reg - CW'(1));
            olst_pkg::PTR_IDX:  ptr_next = idx_reg;
            olst_pkg::PTR_ZERO: ptr_next = '0;
            olst_pkg::PTR_INC:  ptr_next = ptr_reg + AW'(1);
            olst_pkg::PTR_DEC:  ptr_next = ptr_reg - AW'(1);
            default:            ptr_next = ptr_reg;
        endcase
    end

    // A result comes either from the controller or, during a search, from
    // a held match that a later match proves not to be the final one.
    always_comb
    begin
        strobe_next = 1'b0;
        status_next = olst_pkg::ST_DONE;
        data_next   = '0;
        where_next  = '0;
        last_next   = 1'b0;
        if (cmd.emit)
        begin
            strobe_next = 1'b1;
            status_next = cmd.emit_status;
            last_next   = 1'b1;
            unique case (cmd.data_sel)
                olst_pkg::DSEL_VALUE:   data_next = value_reg;
                olst_pkg::DSEL_REMOVED: data_next = removed_reg;
                default:                data_next = '0;
            endcase
            unique case (cmd.where_sel)
                olst_pkg::WSEL_IDX:  where_next = PW'(idx_p1);
                olst_pkg::WSEL_PEND: where_next = PW'(pend_pos_reg);
                default:             where_next = '0;
            endcase
        end
        else if (hit && pend_vld_reg)
        begin
            strobe_next = 1'b1;
            data_next   = value_reg;
            where_next  = PW'(pend_pos_reg);
        end
    end

    // Entry memory: one write and one registered read a cycle.
    always_ff @(posedge clk)
    begin
        if (mv_vld_reg)
            mem[mv_dst_reg] <= rd_data_reg;
        else if (cmd.wr_new)
            mem[idx_reg] <= value_reg;
        if (cmd.rd_mode != olst_pkg::RD_NONE)
            rd_data_reg <= mem[ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            ptr_reg      <= '0;
            mv_vld_reg   <= 1'b0;
            sc_vld_reg   <= 1'b0;
            pend_vld_reg <= 1'b0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            ptr_reg    <= ptr_next;
            mv_vld_reg <= (cmd.rd_mode == olst_pkg::RD_UP) ||
                          (cmd.rd_mode == olst_pkg::RD_DN);
            sc_vld_reg <= (cmd.rd_mode == olst_pkg::RD_SCAN);
            strobe_reg <= strobe_next;
            if (cmd.load)
                pend_vld_reg <= 1'b0;
            else if (hit)
                pend_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            value_reg <= value;
            pos_reg   <= position;
            idx_reg   <= idx_load;
        end
        if (cmd.cap_data)
            removed_reg <= rd_data_reg;
        if (cmd.rd_mode == olst_pkg::RD_UP)
            mv_dst_reg <= ptr_reg + AW'(1);
        else
            mv_dst_reg <= ptr_reg - AW'(1);
        sc_pos_reg <= ptr_p1;
        if (hit)
            pend_pos_reg <= sc_pos_reg;
        status_reg <= status_next;
        data_reg   <= data_next;
        where_reg  <= where_next;
        length_reg <= count_next;
        last_reg   <= last_next;
    end

    assign strobe   = strobe_reg;
    assign status   = status_reg;
    assign data_out = data_reg;
    assign where    = where_reg;
    assign length   = length_reg;
    assign last     = last_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count exceeds the list depth");

    a_write_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(mv_vld_reg && cmd.wr_new))
        else $error("new entry write collides with a pending move");

    a_count_result: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.cnt_op != olst_pkg::CNT_HOLD) |=> strobe_reg && last_reg)
        else $error("entry count changed without a final result");

endmodule
`default_nettype wire

### sv/olst_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// olst_ctrl : ordered list controller
// Sequences each request through checks, shift or scan passes and the
// final result, issuing commands to the datapath.
// ----------------------------------------------------------------------------
module olst_ctrl (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [olst_pkg::KIND_W-1:0] kind,
    input  wire olst_pkg::dp_stat_t          stat,
    output olst_pkg::dp_cmd_t                cmd,
    output logic                             busy
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_INS_SHIFT,
        S_INS_DRAIN,
        S_INS_WR,
        S_DEL_RD,
        S_DEL_CAP,
        S_DEL_SHIFT,
        S_DEL_DRAIN,
        S_DEL_FIN,
        S_SCAN,
        S_SCAN_DRAIN,
        S_SCAN_END
    } state_t;

    state_t              state_reg, state_next;
    logic                busy_reg, busy_next;
    olst_pkg::op_kind_t  kind_reg, kind_next;

    always_comb
    begin
        state_next = state_reg;
        busy_next  = busy_reg;
        kind_next  = kind_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start && !busy_reg)
                begin
                    cmd.load = 1'b1;
                    if (kind != olst_pkg::KIND_UNUSED)
                    begin
                        kind_next  = olst_pkg::op_kind_t'(kind);
                        busy_next  = 1'b1;
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                unique case (kind_reg)
                    olst_pkg::K_INS_FIRST,
                    olst_pkg::K_INS_LAST,
                    olst_pkg::K_INS_AT:
                    begin
                        priority if (kind_reg == olst_pkg::K_INS_AT && stat.ins_bad)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = olst_pkg::ST_BADPOS;
                        end
                        else if (stat.cnt_full)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = olst_pkg::ST_FULL;
                        end
                        else if (stat.idx_eq_cnt)
                            state_next = S_INS_WR;
                        else
                        begin
                            cmd.ptr_op = olst_pkg::PTR_TOP;
                            state_next = S_INS_SHIFT;
                        end
                    end
                    olst_pkg::K_DEL_FIRST,
                    olst_pkg::K_DEL_LAST,
                    olst_pkg::K_DEL_AT:
                    begin
                        priority if (stat.cnt_zero)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = olst_pkg::ST_EMPTY;
                        end
                        else if (kind_reg == olst_pkg::K_DEL_AT && stat.del_bad)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = olst_pkg::ST_BADPOS;
                        end
                        else
                        begin
                            cmd.ptr_op = olst_pkg::PTR_IDX;
                            state_next = S_DEL_RD;
                        end
                    end
                    default:
                    begin
                        if (stat.cnt_zero)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = olst_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            cmd.ptr_op = olst_pkg::PTR_ZERO;
                            state_next = S_SCAN;
                        end
                    end
                endcase
                if (cmd.emit)
                begin
                    busy_next  = 1'b0;
                    state_next = S_IDLE;
                end
            end
            S_INS_SHIFT:
            begin
                cmd.rd_mode = olst_pkg::RD_UP;
                if (stat.ptr_at_idx)
                    state_next = S_INS_DRAIN;
                else
                    cmd.ptr_op = olst_pkg::PTR_DEC;
            end
            S_INS_DRAIN:
                state_next = S_INS_WR;
            S_INS_WR:
            begin
                cmd.wr_new      = 1'b1;
                cmd.cnt_op      = olst_pkg::CNT_INC;
                cmd.emit        = 1'b1;
                cmd.emit_status = olst_pkg::ST_DONE;
                cmd.data_sel    = olst_pkg::DSEL_VALUE;
                cmd.where_sel   = olst_pkg::WSEL_IDX;
                busy_next       = 1'b0;
                state_next      = S_IDLE;
            end
            S_DEL_RD:
            begin
                cmd.rd_mode = olst_pkg::RD_PLAIN;
                state_next  = S_DEL_CAP;
            end
            S_DEL_CAP:
            begin
                cmd.cap_data = 1'b1;
                if (stat.idx_at_top)
                    state_next = S_DEL_FIN;
                else
                begin
                    cmd.ptr_op = olst_pkg::PTR_INC;
                    state_next = S_DEL_SHIFT;
                end
            end
            S_DEL_SHIFT:
            begin
                cmd.rd_mode = olst_pkg::RD_DN;
                if (stat.ptr_at_top)
                    state_next = S_DEL_DRAIN;
                else
                    cmd.ptr_op = olst_pkg::PTR_INC;
            end
            S_DEL_DRAIN:
                state_next = S_DEL_FIN;
            S_DEL_FIN:
            begin
                cmd.cnt_op      = olst_pkg::CNT_DEC;
                cmd.emit        = 1'b1;
                cmd.emit_status = olst_pkg::ST_DONE;
                cmd.data_sel    = olst_pkg::DSEL_REMOVED;
                cmd.where_sel   = olst_pkg::WSEL_IDX;
                busy_next       = 1'b0;
                state_next      = S_IDLE;
            end
            S_SCAN:
            begin
                cmd.rd_mode = olst_pkg::RD_SCAN;
                if (stat.ptr_at_top)
                    state_next = S_SCAN_DRAIN;
                else
                    cmd.ptr_op = olst_pkg::PTR_INC;
            end
            S_SCAN_DRAIN:
                state_next = S_SCAN_END;
            S_SCAN_END:
            begin
                cmd.emit = 1'b1;
                if (stat.pend_vld)
                begin
                    cmd.emit_status = olst_pkg::ST_DONE;
                    cmd.data_sel    = olst_pkg::DSEL_VALUE;
                    cmd.where_sel   = olst_pkg::WSEL_PEND;
                end
                else
                    cmd.emit_status = olst_pkg::ST_NOTFOUND;
                busy_next  = 1'b0;
                state_next = S_IDLE;
            end
            default:
            begin
                busy_next  = 1'b0;
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            kind_reg  <= olst_pkg::K_SEARCH;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            kind_reg  <= kind_next;
        end
    end

    assign busy = busy_reg;

    a_busy_state: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg == (state_reg != S_IDLE)))
        else $error("busy flag disagrees with controller state");

    a_emit_ends: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> !busy_reg)
        else $error("controller stayed busy after the final result");

endmodule
`default_nettype wire

### sv/ordered_list_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_list_engine : bounded ordered list with positional edits and search
// Holds up to DEPTH signed 32-bit values in order and performs insert,
// delete and search requests, reporting each outcome on a result strobe.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                 Payload
//  --------  ------------------------  ---------------------------------------
//  request   start, accepted if !busy  kind, value, position
//  result    strobe, one cycle each    status, data_out, where, length, last
//
// An error outcome is reported from the check that follows acceptance; an
// insert moves the entries from the target index up and a delete moves
// those above it, one entry at a time, and a search compares every entry
// held. Each entry moved or compared takes one read of the single read
// port of the entry memory.
// busy stays high from acceptance until the cycle in which the final result
// (last high) is on the ports, so the next request may be accepted then.
// Search matches are shown one per strobe in ascending order; the receiver
// cannot stall the block, and every result must be taken in its cycle.
// Reset clears the entry count and the controller at once; the entry memory
// itself is never cleared, as only written entries below the count are read.
// An operation code of 7 is accepted, does nothing and gives no result.
//
module ordered_list_engine #(
    parameter int DEPTH = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [olst_pkg::KIND_W-1:0]        kind,
    input  wire logic signed [olst_pkg::VAL_W-1:0]  value,
    input  wire logic [olst_pkg::POS_W-1:0]         position,
    output logic                                    strobe,
    output logic [olst_pkg::STAT_W-1:0]             status,
    output logic signed [olst_pkg::VAL_W-1:0]       data_out,
    output logic [olst_pkg::POS_W-1:0]              where,
    output logic [$clog2(DEPTH+1)-1:0]              length,
    output logic                                    last
);

    // Commands from the controller and status flags back from the datapath.
    olst_pkg::dp_cmd_t  cmd;
    olst_pkg::dp_stat_t stat;

    // The controller owns sequencing and the busy flag; it sees only the
    // operation code of a request and the datapath's summary flags.
    olst_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .kind  (kind),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // The datapath holds the entries, the count and the result register.
    // Shifts are pipelined through the registered read port, so that one
    // entry moves per cycle.
    olst_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .kind     (kind),
        .value    (value),
        .position (position),
        .cmd      (cmd),
        .stat     (stat),
        .strobe   (strobe),
        .status   (status),
        .data_out (data_out),
        .where    (where),
        .length   (length),
        .last     (last)
    );

endmodule
`default_nettype wire

### test/ordered_list_engine_tb.sv
// ----------------------------------------------------------------------------
// ordered_list_engine_tb : self-checking bench for the ordered list engine
// Drives insert, delete and search requests through the start/busy handshake,
// keeps its own copy of the list to work out every result, and compares each
// strobed result, field by field, with the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module ordered_list_engine_tb;

    localparam int DEPTH      = 16;
    localparam int LEN_W      = $clog2(DEPTH + 1);
    localparam int KIND_W     = olst_pkg::KIND_W;
    localparam int VAL_W      = olst_pkg::VAL_W;
    localparam int POS_W      = olst_pkg::POS_W;
    localparam int STAT_W     = olst_pkg::STAT_W;
    // Cycles with neither a request accepted nor a result strobed before the
    // run is abandoned. The limit lies far above the longest single request
    // plus the longest sender idle, so it leaves a wide margin.
    localparam int STALL_LIMIT = 400;
    // Quiet cycles allowed after the last result, more than the longest
    // request, so that any stray strobe still gets caught.
    localparam int DRAIN_CYCLES = 40;

    // One expected result, laid out as the result ports are.
    typedef struct packed {
        olst_pkg::status_t       status;
        logic signed [VAL_W-1:0] data;
        logic [POS_W-1:0]        where;
        logic [LEN_W-1:0]        length;
        logic                    last;
    } list_result_t;

    logic                    clk      = 1'b0;
    logic                    rst_n    = 1'b0;
    logic                    start    = 1'b0;
    logic [KIND_W-1:0]       kind     = '0;
    logic signed [VAL_W-1:0] value    = '0;
    logic [POS_W-1:0]        position = '0;

    logic                    busy;
    logic                    strobe;
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] data_out;
    logic [POS_W-1:0]        where;
    logic [LEN_W-1:0]        length;
    logic                    last;

    // The bench's own image of the list, updated as each request is taken.
    logic signed [VAL_W-1:0] list_vals [DEPTH];
    int                      list_count = 0;

    // Results that the accepted requests are still owed, oldest first.
    list_result_t            owed_results [$];

    int                      fail_count  = 0;
    int                      quiet_count = 0;
    // Chance, in percent, that the sender idles after a request.
    int                      gap_pct     = 0;

    ordered_list_engine #(
        .DEPTH (DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .kind     (kind),
        .value    (value),
        .position (position),
        .strobe   (strobe),
        .status   (status),
        .data_out (data_out),
        .where    (where),
        .length   (length),
        .last     (last)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------------
    // List prediction
    // ------------------------------------------------------------------------

    // Queue one result; the length field always reports the count after the
    // operation, which is the current count at the point of the call.
    task automatic owe_result(input olst_pkg::status_t st,
                              input logic signed [VAL_W-1:0] d,
                              input int at, input logic fin);
        list_result_t r;
        r.status = st;
        r.data   = d;
        r.where  = at[POS_W-1:0];
        r.length = list_count[LEN_W-1:0];
        r.last   = fin;
        owed_results.push_back(r);
    endtask

    // Apply one accepted request to the list image and queue what it yields.
    // Every error leaves the list untouched and reports zero data and zero
    // position. For a positional insert the position check is made before
    // the full check; for a positional delete the empty check comes first.
    task automatic apply_list_op(input logic [KIND_W-1:0] k,
                                 input logic signed [VAL_W-1:0] v,
                                 input logic [POS_W-1:0] p);
        int                      slot;
        int                      i;
        logic signed [VAL_W-1:0] removed;
        int                      hits [$];
        case (k)
            olst_pkg::K_INS_FIRST, olst_pkg::K_INS_LAST, olst_pkg::K_INS_AT:
            begin
                if (k == olst_pkg::K_INS_FIRST)
                    slot = 1;
                else if (k == olst_pkg::K_INS_LAST)
                    slot = list_count + 1;
                else
                    slot = int'(p);
                if (k == olst_pkg::K_INS_AT && (p == 0 || int'(p) > list_count + 1))
                    owe_result(olst_pkg::ST_BADPOS, '0, 0, 1'b1);
                else if (list_count >= DEPTH)
                    owe_result(olst_pkg::ST_FULL, '0, 0, 1'b1);
                else
                begin
                    for (i = list_count; i > slot - 1; i--)
                        list_vals[i] = list_vals[i - 1];
                    list_vals[slot - 1] = v;
                    list_count++;
                    owe_result(olst_pkg::ST_DONE, v, slot, 1'b1);
                end
            end
            olst_pkg::K_DEL_FIRST, olst_pkg::K_DEL_LAST, olst_pkg::K_DEL_AT:
            begin
                if (k == olst_pkg::K_DEL_FIRST)
                    slot = 1;
                else if (k == olst_pkg::K_DEL_LAST)
                    slot = list_count;
                else
                    slot = int'(p);
                if (list_count == 0)
                    owe_result(olst_pkg::ST_EMPTY, '0, 0, 1'b1);
                else if (k == olst_pkg::K_DEL_AT && (p == 0 || int'(p) > list_count))
                    owe_result(olst_pkg::ST_BADPOS, '0, 0, 1'b1);
                else
                begin
                    removed = list_vals[slot - 1];
                    for (i = slot - 1; i + 1 < list_count; i++)
                        list_vals[i] = list_vals[i + 1];
                    list_count--;
                    owe_result(olst_pkg::ST_DONE, removed, slot, 1'b1);
                end
            end
            olst_pkg::K_SEARCH:
            begin
                if (list_count == 0)
                    owe_result(olst_pkg::ST_EMPTY, '0, 0, 1'b1);
                else
                begin
                    // Matches come out in ascending position order, and only
                    // the final one carries the last flag.
                    for (i = 0; i < list_count; i++)
                        if (list_vals[i] == v)
                            hits.push_back(i + 1);
                    if (hits.size() == 0)
                        owe_result(olst_pkg::ST_NOTFOUND, '0, 0, 1'b1);
                    foreach (hits[j])
                        owe_result(olst_pkg::ST_DONE, v, hits[j], j == hits.size() - 1);
                end
            end
            default:
            begin
                // The unused operation code is taken but yields nothing.
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------------

    // Present one request and hold it until an edge finds busy low. The
    // request is predicted at that edge. Afterwards the sender may idle for
    // a short burst; otherwise start simply stays high for the next request,
    // so it is never lowered and raised within one time step.
    task automatic send_request(input logic [KIND_W-1:0] k,
                                input logic signed [VAL_W-1:0] v,
                                input logic [POS_W-1:0] p);
        int idle;
        kind     <= k;
        value    <= v;
        position <= p;
        start    <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        apply_list_op(k, v, p);
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
        begin
            idle = $urandom_range(1, 6);
            start <= 1'b0;
            repeat (idle) @(posedge clk);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------

    task automatic compare_field(input string name, input logic [VAL_W-1:0] want,
                                 input logic [VAL_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Results cannot be held off, so every strobe seen at an edge is a result
    // taken at that edge and must match the oldest owed result.
    always @(posedge clk)
    begin
        list_result_t owed;
        if (rst_n && strobe)
        begin
            if (owed_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got status %h data %h",
                         $time, status, data_out);
                fail_count++;
            end
            else
            begin
                owed = owed_results.pop_front();
                compare_field("status",   VAL_W'(owed.status), VAL_W'(status));
                compare_field("data_out", owed.data,           data_out);
                compare_field("where",    VAL_W'(owed.where),  VAL_W'(where));
                compare_field("length",   VAL_W'(owed.length), VAL_W'(length));
                compare_field("last",     VAL_W'(owed.last),   VAL_W'(last));
            end
        end
    end

    // Watchdog: any cycle that accepts a request or strobes a result counts
    // as progress; a long run of cycles with neither ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe)
            quiet_count <= 0;
        else if (quiet_count >= STALL_LIMIT)
        begin
            $display("ordered_list_engine_tb: FAIL");
            $finish;
        end
        else
            quiet_count <= quiet_count + 1;
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Value drawn mostly from a small pool, so that searches find matches and
    // duplicates build up, and sometimes from the whole 32-bit range.
    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return -32'sd1;
            3:       return 32'sd0;
            4, 5, 6: return VAL_W'($urandom_range(1, 5));
            default: return $urandom;
        endcase
    endfunction

    // Error cases that an empty list can give: deletes and searches report
    // empty (even with a bad position), and positional inserts at position
    // zero or beyond the end are refused.
    task automatic test_empty_list();
        send_request(olst_pkg::K_DEL_FIRST, 32'sd9, 16'd0);
        send_request(olst_pkg::K_DEL_LAST,  32'sd9, 16'd0);
        send_request(olst_pkg::K_DEL_AT,    32'sd9, 16'd1);
        send_request(olst_pkg::K_DEL_AT,    32'sd9, 16'd0);
        send_request(olst_pkg::K_SEARCH,    32'sd0, 16'd0);
        send_request(olst_pkg::K_INS_AT,    32'sd3, 16'd0);
        send_request(olst_pkg::K_INS_AT,    32'sd3, 16'd2);
        send_request(olst_pkg::K_INS_AT,    32'sd3, 16'hFFFF);
    endtask

    // Inserts and deletes at the front, the back and in the middle, with the
    // extreme values and positions, a found and a missed search, and the
    // unused operation code in between.
    task automatic test_positional_edits();
        send_request(olst_pkg::K_INS_FIRST, 32'sh7FFF_FFFF, 16'hFFFF);
        send_request(olst_pkg::K_INS_LAST,  32'sh8000_0000, 16'd0);
        send_request(olst_pkg::K_INS_AT,    -32'sd1,        16'd2);
        send_request(olst_pkg::K_INS_AT,    32'sd0,         16'd4);
        send_request(olst_pkg::K_INS_AT,    32'sd8,         16'd6);
        send_request(olst_pkg::K_SEARCH,    -32'sd1,        16'd0);
        send_request(olst_pkg::K_SEARCH,    32'sd12345,     16'd0);
        send_request(olst_pkg::KIND_UNUSED, 32'sd77,        16'd1);
        send_request(olst_pkg::K_DEL_AT,    32'sd0,         16'd0);
        send_request(olst_pkg::K_DEL_AT,    32'sd0,         16'd5);
        send_request(olst_pkg::K_DEL_AT,    32'sd0,         16'hFFFF);
        send_request(olst_pkg::K_DEL_AT,    32'sd0,         16'd2);
        send_request(olst_pkg::K_DEL_FIRST, 32'sd0,         16'd0);
        send_request(olst_pkg::K_DEL_LAST,  32'sd0,         16'd0);
        send_request(olst_pkg::K_DEL_AT,    32'sd0,         16'd1);
    endtask

    // Fill the list to DEPTH with one repeated value, so that a search yields
    // the largest burst of matches, then try every insert on the full list
    // (the position check still wins over the full check) and drain it.
    task automatic test_full_list();
        int i;
        for (i = 0; i < DEPTH; i++)
            if (i % 3 == 2)
                send_request(olst_pkg::K_INS_AT, 32'sd5,
                             POS_W'($urandom_range(1, list_count + 1)));
            else
                send_request(olst_pkg::K_INS_LAST, 32'sd5, 16'd0);
        send_request(olst_pkg::K_INS_FIRST, 32'sd6, 16'd0);
        send_request(olst_pkg::K_INS_LAST,  32'sd6, 16'd0);
        send_request(olst_pkg::K_INS_AT,    32'sd6, POS_W'(DEPTH + 1));
        send_request(olst_pkg::K_INS_AT,    32'sd6, POS_W'(DEPTH + 2));
        send_request(olst_pkg::K_SEARCH,    32'sd5, 16'd0);
        send_request(olst_pkg::K_DEL_AT,    32'sd0, POS_W'(DEPTH));
        send_request(olst_pkg::K_INS_AT,    32'sd4, 16'd8);
        send_request(olst_pkg::K_SEARCH,    32'sd5, 16'd0);
        while (list_count > 0)
            case ($urandom_range(0, 2))
                0:       send_request(olst_pkg::K_DEL_FIRST, 32'sd0, 16'd0);
                1:       send_request(olst_pkg::K_DEL_LAST,  32'sd0, 16'd0);
                default: send_request(olst_pkg::K_DEL_AT, 32'sd0,
                                      POS_W'($urandom_range(1, list_count)));
            endcase
    endtask

    // Random requests. The list swings between filling and draining phases
    // so that it passes through empty and full again and again; most
    // positions are in range, the rest are noise across the whole field.
    // Sender idling comes and goes in stretches and stops near the end.
    task automatic test_random_mix(input int n_requests);
        int                      i;
        int                      roll;
        logic                    filling;
        logic [KIND_W-1:0]       k;
        logic [POS_W-1:0]        p;
        filling = 1'b1;
        for (i = 0; i < n_requests; i++)
        begin
            if (i >= n_requests - 30)
                gap_pct = 0;
            else if (i % 20 == 0)
                gap_pct = ($urandom_range(0, 1) != 0) ? 35 : 0;
            if (list_count >= DEPTH)
                filling = 1'b0;
            else if (list_count == 0)
                filling = 1'b1;
            roll = $urandom_range(0, 99);
            if (roll < 3)
                k = olst_pkg::KIND_UNUSED;
            else if (roll < 25)
                k = olst_pkg::K_SEARCH;
            else if ((roll < 75) == filling)
                k = KIND_W'($urandom_range(olst_pkg::K_INS_FIRST, olst_pkg::K_INS_AT));
            else
                k = KIND_W'($urandom_range(olst_pkg::K_DEL_FIRST, olst_pkg::K_DEL_AT));
            if ($urandom_range(0, 99) < 15)
                p = POS_W'($urandom_range(0, 16'hFFFF));
            else if (k == olst_pkg::K_INS_AT)
                p = POS_W'($urandom_range(1, list_count + 1));
            else if (list_count > 0)
                p = POS_W'($urandom_range(1, list_count));
            else
                p = 16'd1;
            send_request(k, pick_value(), p);
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        gap_pct = 0;
        test_empty_list();
        gap_pct = 40;
        test_positional_edits();
        gap_pct = 25;
        test_full_list();
        test_random_mix(48);

        // Stop requesting, let the owed results arrive, then keep watching
        // for a while for anything that should not be there.
        start <= 1'b0;
        while (owed_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("ordered_list_engine_tb: PASS");
        else
            $display("ordered_list_engine_tb: FAIL");
        $finish;
    end

endmodule
